/* src/tpdf_pkg.sv */
// ----------------------------------------------------------------------------
// tpdf_pkg
// Types and constants shared by the touch debounce filter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpdf_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELEASE = 1'b1;

  localparam logic [COUNT_W-1:0] PRESS_CNT_RST   = 4'd3;
  localparam logic [COUNT_W-1:0] RELEASE_CNT_RST = 4'd3;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               touch_active;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] press_cnt;
    logic [COUNT_W-1:0] release_cnt;
  } cfg_t;

endpackage

/* src/tpdf_if.sv */
// ----------------------------------------------------------------------------
// tpdf_if
// Valid/ready channels for raw touch samples and filtered results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpdf_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_x;
  logic [15:0] raw_y;
  logic        raw_pressed;

  modport source (output valid, output raw_x, output raw_y, output raw_pressed,
                  input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_pressed,
                output ready);
endinterface

interface tpdf_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic        touch_active;

  modport source (output valid, output out_x, output out_y, output touch_active,
                  input ready);
  modport sink (input valid, input out_x, input out_y, input touch_active,
                output ready);
endinterface

/* src/tpdf_core.sv */
// ----------------------------------------------------------------------------
// tpdf_core
// Press/release run counters, confirmed state and coordinate smoothing.
// Presents the updated held state as the result of the accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpdf_core
  import tpdf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [COORD_W-1:0] raw_x_i,
  input  logic [COORD_W-1:0] raw_y_i,
  input  logic               raw_pressed_i,
  input  cfg_t               cfg_i,
  output result_t            result_o
);

  logic [COUNT_W-1:0] press_run_q, press_run_d;
  logic [COUNT_W-1:0] release_run_q, release_run_d;
  logic               pressed_q, pressed_d;
  logic [COORD_W-1:0] held_x_q, held_x_d;
  logic [COORD_W-1:0] held_y_q, held_y_d;

  function automatic logic [COORD_W-1:0] smooth(input logic [COORD_W-1:0] old_v,
                                                input logic [COORD_W-1:0] new_v);
    logic [COORD_W+1:0] sum;
    sum = ({2'b00, old_v} << 1) + {2'b00, old_v} + {2'b00, new_v} + 18'd2;
    return sum[COORD_W+1:2];
  endfunction

  always_comb begin
    press_run_d   = press_run_q;
    release_run_d = release_run_q;
    pressed_d     = pressed_q;
    held_x_d      = held_x_q;
    held_y_d      = held_y_q;
    if (raw_pressed_i) begin
      if (press_run_q < cfg_i.press_cnt) begin
        press_run_d = press_run_q + 4'd1;
      end
      release_run_d = '0;
      if (!pressed_q && (press_run_d >= cfg_i.press_cnt)) begin
        pressed_d = 1'b1;
        held_x_d  = raw_x_i;
        held_y_d  = raw_y_i;
      end else if (pressed_q) begin
        held_x_d = smooth(held_x_q, raw_x_i);
        held_y_d = smooth(held_y_q, raw_y_i);
      end
    end else begin
      if (release_run_q < cfg_i.release_cnt) begin
        release_run_d = release_run_q + 4'd1;
      end
      press_run_d = '0;
      if (release_run_d >= cfg_i.release_cnt) begin
        pressed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_run_q   <= '0;
      release_run_q <= '0;
      pressed_q     <= 1'b0;
      held_x_q      <= '0;
      held_y_q      <= '0;
    end else if (accept_i) begin
      press_run_q   <= press_run_d;
      release_run_q <= release_run_d;
      pressed_q     <= pressed_d;
      held_x_q      <= held_x_d;
      held_y_q      <= held_y_d;
    end
  end

  assign result_o.out_x        = held_x_d;
  assign result_o.out_y        = held_y_d;
  assign result_o.touch_active = pressed_d;

endmodule

/* src/touch_press_debounce_filter_top.sv */
// ----------------------------------------------------------------------------
// touch_press_debounce_filter_top
// Touch press debounce with IIR coordinate smoothing.
// ----------------------------------------------------------------------------
// Takes one raw sample word per cycle and returns one registered result word
// per sample. The debounce counters and 3:1 smoothing update are combinational,
// so the rate is one word per clock while ready is high. A two-word output
// buffer (result register plus skid register) lets a sample be taken while a
// result is stalled; input ready drops only when both are full. Thresholds are
// written via cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while the block
// is idle (unchecked); index 0 is the press count, index 1 the release count.
`timescale 1ns / 1ps

module touch_press_debounce_filter_top
  import tpdf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COUNT_W-1:0]   cfg_data_i,
  tpdf_sample_if.sink          sample_i,
  tpdf_result_if.source        result_o
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    accept;
  logic    out_free;

  assign sample_i.ready = !skid_valid_q;
  assign accept         = sample_i.valid && !skid_valid_q;
  assign out_free       = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_cnt   <= PRESS_CNT_RST;
      cfg_q.release_cnt <= RELEASE_CNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_PRESS:   cfg_q.press_cnt   <= cfg_data_i;
        CFG_IDX_RELEASE: cfg_q.release_cnt <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpdf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .raw_x_i       (sample_i.raw_x),
    .raw_y_i       (sample_i.raw_y),
    .raw_pressed_i (sample_i.raw_pressed),
    .cfg_i         (cfg_q),
    .result_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.out_x        = out_q.out_x;
  assign result_o.out_y        = out_q.out_y;
  assign result_o.touch_active = out_q.touch_active;

endmodule
